/* sv/mwprc_pkg.sv */
// mwprc_pkg: shared types and constants for the window page RAM controller
// no dependencies; used by the interfaces, the decoder and the top level
`default_nettype none

package mwprc_pkg;

  // page RAM size and derived address width
  localparam int RAM_BYTES = 2048;
  localparam int RamAw     = $clog2(RAM_BYTES);

  // window pages (upper address byte)
  localparam logic [7:0] WIN_LO_PAGE = 8'hCC;
  localparam logic [7:0] WIN_HI_PAGE = 8'hCE;

  // window offsets
  localparam logic [9:0] OFF_IWM_RST   = 10'h040;
  localparam logic [9:0] OFF_DRV_ON    = 10'h080;
  localparam logic [9:0] OFF_DRV_ON_E  = 10'h09F;
  localparam logic [9:0] OFF_DRV_OFF   = 10'h0C0;
  localparam logic [9:0] OFF_DRV_OFF_E = 10'h0DF;
  localparam logic [9:0] OFF_RAM       = 10'h200;
  localparam logic [9:0] OFF_RAM_E     = 10'h21F;
  localparam logic [9:0] OFF_RAM_ADV   = 10'h220;
  localparam logic [9:0] OFF_RAM_ADV_E = 10'h23F;
  localparam logic [9:0] OFF_SEL0      = 10'h240;
  localparam logic [9:0] OFF_SEL0_E    = 10'h25F;
  localparam logic [9:0] OFF_SEL1      = 10'h260;
  localparam logic [9:0] OFF_SEL1_E    = 10'h27F;
  localparam logic [9:0] OFF_CUR_CLR   = 10'h2A0;

  localparam int CursorStep = 32;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // architectural state that carries from item to item
  typedef struct packed {
    logic             bank;
    logic [RamAw-1:0] cursor;
    logic             head;
    logic             int_drive;
    logic             sel35;
  } ctl_state_t;

  // per-item actions from the decoder
  typedef struct packed {
    logic             handled;
    logic             ram_rd;
    logic             ram_wr;
    logic [RamAw-1:0] ram_idx;
    logic             iwm_pulse;
    logic             fbus_rd;
  } ctl_act_t;

endpackage

`default_nettype wire

/* sv/mwprc_if.sv */
// mwprc_req_if / mwprc_rsp_if: valid/ready channels for bus items and results
// depends on mwprc_pkg for nothing but house consistency of widths
`default_nettype none

interface mwprc_req_if;
  import mwprc_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [15:0] bus_address;
  logic [7:0] write_data;
  logic [7:0] floating_bus;

  modport source (output valid, cmd, bus_address, write_data, floating_bus, input ready);
  modport sink   (input valid, cmd, bus_address, write_data, floating_bus, output ready);
endinterface

interface mwprc_rsp_if;
  import mwprc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       handled;
  logic       rom_bank;
  logic       head_one;
  logic       internal_drive;
  logic       select_35;
  logic       iwm_reset_pulse;

  modport source (output valid, read_data, handled, rom_bank, head_one, internal_drive,
                  select_35, iwm_reset_pulse, input ready);
  modport sink   (input valid, read_data, handled, rom_bank, head_one, internal_drive,
                  select_35, iwm_reset_pulse, output ready);
endinterface

`default_nettype wire

/* sv/mig_window_page_ram_controller_core.sv */
// mig_window_page_ram_controller_core: top level with page RAM, control state and result pipe
// depends on mwprc_pkg, mwprc_req_if, mwprc_rsp_if and mwprc_decode
//
//   channel   dir   handshake      payload
//   req_i     in    valid/ready    cmd, bus_address, write_data, floating_bus
//   rsp_o     out   valid/ready    read_data, handled, rom_bank, head_one,
//                                  internal_drive, select_35, iwm_reset_pulse
//   cfg       in    cfg_we_i       cfg_wdata_i (enhanced model flag)
//
// one item per cycle sustained while rsp_o.ready is high; a result is registered in stage 1
// (ram read register) and then in the result register
// after reset the page RAM is zeroed one byte a cycle, with req_i.ready low until
// the sweep ends; config writes are taken during that time
// a stalled result holds the pipe; the two stages keep full rate with ready high
`default_nettype none

module mig_window_page_ram_controller_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  mwprc_req_if.sink   req_i,
  mwprc_rsp_if.source rsp_o
);
  import mwprc_pkg::*;

  logic             enh_q;
  ctl_state_t       st_q, st_d;
  ctl_act_t         act;
  logic             clr_q;
  logic [RamAw-1:0] clr_cnt_q;
  logic             in_xfer;

  logic [7:0]       ram_q [RAM_BYTES];
  logic [7:0]       ram_rdata_q;
  logic             mem_we;
  logic [RamAw-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  logic             s1_valid_q;
  logic             s1_use_ram_q;
  logic [7:0]       s1_data_q;
  logic             s1_handled_q;
  ctl_state_t       s1_st_q;
  logic             s1_pulse_q;
  logic             s1_adv;

  logic             out_valid_q;
  logic             out_free;

  // item decode
  mwprc_decode u_decode (
    .enh_i  (enh_q),
    .cmd_i  (req_i.cmd),
    .addr_i (req_i.bus_address),
    .st_i   (st_q),
    .st_o   (st_d),
    .act_o  (act)
  );

  // flow control
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign req_i.ready = !clr_q && (!s1_valid_q || out_free);
  assign in_xfer     = req_i.valid && req_i.ready;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enh_q <= 1'b0;
    end else if (cfg_we_i) begin
      enh_q <= cfg_wdata_i;
    end
  end

  // control state and ram clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (in_xfer) begin
        st_q <= st_d;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == RamAw'(RAM_BYTES - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // page ram write port select
  assign mem_we    = clr_q || (in_xfer && act.ram_wr);
  assign mem_waddr = clr_q ? clr_cnt_q : act.ram_idx;
  assign mem_wdata = clr_q ? 8'h00 : req_i.write_data;

  // page ram
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ram_q[mem_waddr] <= mem_wdata;
    end
    if (in_xfer && act.ram_rd) begin
      ram_rdata_q <= ram_q[act.ram_idx];
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_use_ram_q <= act.ram_rd;
      s1_data_q    <= act.fbus_rd ? req_i.floating_bus : 8'h00;
      s1_handled_q <= act.handled;
      s1_st_q      <= st_d;
      s1_pulse_q   <= act.iwm_pulse;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_o.read_data       <= s1_use_ram_q ? ram_rdata_q : s1_data_q;
      rsp_o.handled         <= s1_handled_q;
      rsp_o.rom_bank        <= s1_st_q.bank;
      rsp_o.head_one        <= s1_st_q.head;
      rsp_o.internal_drive  <= s1_st_q.int_drive;
      rsp_o.select_35       <= s1_st_q.sel35;
      rsp_o.iwm_reset_pulse <= s1_pulse_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

endmodule

`default_nettype wire

/* sv/mwprc_decode.sv */
// mwprc_decode: window decode, next control state and RAM action for one item
// depends on mwprc_pkg
`default_nettype none

module mwprc_decode (
  input  wire logic                   enh_i,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [15:0]            addr_i,
  input  wire mwprc_pkg::ctl_state_t  st_i,
  output mwprc_pkg::ctl_state_t       st_o,
  output mwprc_pkg::ctl_act_t         act_o
);
  import mwprc_pkg::*;

  logic             active;
  logic [9:0]       off;
  logic [RamAw:0]   idx_sum;
  logic [RamAw:0]   adv_sum;
  logic [RamAw-1:0] idx;
  logic [RamAw-1:0] cur_adv;

  // window hit and offset (both windows line up with address bits 9:0)
  assign active = enh_i && st_i.bank &&
                  ((addr_i[15:8] == WIN_LO_PAGE) || (addr_i[15:8] == WIN_HI_PAGE));
  assign off    = addr_i[9:0];

  // ram index with wrap at the RAM size
  assign idx_sum = {1'b0, st_i.cursor} + (RamAw+1)'(off[4:0]);
  assign idx     = (idx_sum >= (RamAw+1)'(RAM_BYTES)) ?
                   RamAw'(idx_sum - (RamAw+1)'(RAM_BYTES)) : idx_sum[RamAw-1:0];

  // cursor advance by one page, back to zero at the end
  assign adv_sum = {1'b0, st_i.cursor} + (RamAw+1)'(CursorStep);
  assign cur_adv = (adv_sum >= (RamAw+1)'(RAM_BYTES)) ? '0 : adv_sum[RamAw-1:0];

  // command decode
  always_comb begin
    st_o          = st_i;
    act_o         = '0;
    act_o.ram_idx = idx;
    case (cmd_e'(cmd_i))
      CMD_READ: begin
        if (active) begin
          act_o.handled = 1'b1;
          if (off inside {[OFF_RAM:OFF_RAM_E]}) begin
            act_o.ram_rd = 1'b1;
          end else if (off inside {[OFF_RAM_ADV:OFF_RAM_ADV_E]}) begin
            act_o.ram_rd = 1'b1;
            st_o.cursor  = cur_adv;
          end else begin
            act_o.fbus_rd = 1'b1;
            if (off inside {[OFF_SEL0:OFF_SEL0_E]}) begin
              st_o.head = 1'b0;
            end else if (off inside {[OFF_SEL1:OFF_SEL1_E]}) begin
              st_o.head = 1'b1;
            end else if (off == OFF_CUR_CLR) begin
              st_o.cursor = '0;
            end
          end
        end
      end
      CMD_WRITE: begin
        if (active) begin
          act_o.handled = 1'b1;
          if (off == OFF_IWM_RST) begin
            act_o.iwm_pulse = 1'b1;
          end else if (off inside {[OFF_DRV_ON:OFF_DRV_ON_E]}) begin
            st_o.int_drive = 1'b1;
          end else if (off inside {[OFF_DRV_OFF:OFF_DRV_OFF_E]}) begin
            st_o.int_drive = 1'b0;
          end else if (off inside {[OFF_RAM:OFF_RAM_E]}) begin
            act_o.ram_wr = 1'b1;
          end else if (off inside {[OFF_RAM_ADV:OFF_RAM_ADV_E]}) begin
            act_o.ram_wr = 1'b1;
            st_o.cursor  = cur_adv;
          end else if (off inside {[OFF_SEL0:OFF_SEL0_E]}) begin
            st_o.sel35 = 1'b0;
          end else if (off inside {[OFF_SEL1:OFF_SEL1_E]}) begin
            st_o.sel35 = 1'b1;
          end else if (off == OFF_CUR_CLR) begin
            st_o.cursor = '0;
          end
        end
      end
      CMD_TOGGLE: begin
        st_o.bank = ~st_i.bank;
        if (st_i.bank) begin
          st_o.cursor    = '0;
          st_o.int_drive = 1'b0;
          st_o.sel35     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/mig_window_page_ram_controller_core_tb.sv */
// testbench for mig_window_page_ram_controller_core: bus items in, one result per item out
// depends on mwprc_pkg and the mwprc_req_if / mwprc_rsp_if channel interfaces
// a tracker class predicts each result from its own copy of the chip state and checks it
`timescale 1ns / 100ps

module mig_window_page_ram_controller_core_tb;
  import mwprc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  // expected state of the window chip, updated per accepted transfer
  class window_ctl_tracker;
    typedef struct packed {
      logic [7:0] read_data;
      logic       handled;
      logic       rom_bank;
      logic       head_one;
      logic       internal_drive;
      logic       select_35;
      logic       iwm_reset_pulse;
    } chip_rsp_t;

    bit             enhanced;
    bit             bank;
    bit [RamAw-1:0] cursor;
    bit             head;
    bit             drive;
    bit             sel35;
    bit [7:0]       ram [RAM_BYTES];
    chip_rsp_t      want_rsp_q[$];
    int             errors;

    function new();
      enhanced = 0;
      bank     = 0;
      cursor   = '0;
      head     = 0;
      drive    = 0;
      sel35    = 0;
      errors   = 0;
      foreach (ram[i]) ram[i] = 8'h00;
    endfunction

    function int pending();
      return want_rsp_q.size();
    endfunction

    function int page_index(logic [9:0] off);
      return (int'(cursor) + int'(off[4:0])) % RAM_BYTES;
    endfunction

    function void step_cursor();
      int nxt;
      nxt = int'(cursor) + CursorStep;
      if (nxt >= RAM_BYTES) nxt = 0;
      cursor = nxt[RamAw-1:0];
    endfunction

    function bit in_range(logic [9:0] off, logic [9:0] lo, logic [9:0] hi);
      return off >= lo && off <= hi;
    endfunction

    // work out the result of one accepted bus item
    function void note_bus_item(cmd_e cmd, logic [15:0] addr, logic [7:0] wdata,
                                logic [7:0] fbus);
      chip_rsp_t   r;
      logic [15:0] rel;
      logic [9:0]  off;
      bit          in_win;
      bit          active;
      rel    = addr - {WIN_LO_PAGE, 8'h00};
      off    = rel[9:0];
      in_win = addr[15:8] == WIN_LO_PAGE || addr[15:8] == WIN_HI_PAGE;
      active = enhanced && bank && in_win;
      r      = '0;
      case (cmd)
        CMD_READ: begin
          if (active) begin
            r.handled = 1'b1;
            if (in_range(off, OFF_RAM, OFF_RAM_E)) begin
              r.read_data = ram[page_index(off)];
            end else if (in_range(off, OFF_RAM_ADV, OFF_RAM_ADV_E)) begin
              r.read_data = ram[page_index(off)];
              step_cursor();
            end else begin
              if (in_range(off, OFF_SEL0, OFF_SEL0_E)) head = 0;
              if (in_range(off, OFF_SEL1, OFF_SEL1_E)) head = 1;
              if (off == OFF_CUR_CLR) cursor = '0;
              r.read_data = fbus;
            end
          end
        end
        CMD_WRITE: begin
          if (active) begin
            r.handled = 1'b1;
            if (off == OFF_IWM_RST) r.iwm_reset_pulse = 1'b1;
            else if (in_range(off, OFF_DRV_ON, OFF_DRV_ON_E)) drive = 1;
            else if (in_range(off, OFF_DRV_OFF, OFF_DRV_OFF_E)) drive = 0;
            else if (in_range(off, OFF_RAM, OFF_RAM_E)) ram[page_index(off)] = wdata;
            else if (in_range(off, OFF_RAM_ADV, OFF_RAM_ADV_E)) begin
              ram[page_index(off)] = wdata;
              step_cursor();
            end
            else if (in_range(off, OFF_SEL0, OFF_SEL0_E)) sel35 = 0;
            else if (in_range(off, OFF_SEL1, OFF_SEL1_E)) sel35 = 1;
            else if (off == OFF_CUR_CLR) cursor = '0;
          end
        end
        CMD_TOGGLE: begin
          bank = ~bank;
          // back to bank 0 drops the cursor and the drive latches
          if (!bank) begin
            cursor = '0;
            drive  = 0;
            sel35  = 0;
          end
        end
        default: ;
      endcase
      r.rom_bank       = bank;
      r.head_one       = head;
      r.internal_drive = drive;
      r.select_35      = sel35;
      want_rsp_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    // compare one result with the oldest expectation
    task check_rsp(chip_rsp_t got);
      chip_rsp_t want;
      if (want_rsp_q.size() == 0) begin
        report_mismatch("result with none expected", int'(got), 0);
      end else begin
        want = want_rsp_q.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.handled !== want.handled)
          report_mismatch("handled", got.handled, want.handled);
        if (got.rom_bank !== want.rom_bank)
          report_mismatch("rom_bank", got.rom_bank, want.rom_bank);
        if (got.head_one !== want.head_one)
          report_mismatch("head_one", got.head_one, want.head_one);
        if (got.internal_drive !== want.internal_drive)
          report_mismatch("internal_drive", got.internal_drive, want.internal_drive);
        if (got.select_35 !== want.select_35)
          report_mismatch("select_35", got.select_35, want.select_35);
        if (got.iwm_reset_pulse !== want.iwm_reset_pulse)
          report_mismatch("iwm_reset_pulse", got.iwm_reset_pulse, want.iwm_reset_pulse);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  mwprc_req_if req_if ();
  mwprc_rsp_if rsp_if ();

  mig_window_page_ram_controller_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  window_ctl_tracker chip = new();

  int src_idle_pct  = 27;
  int sink_idle_pct = 27;
  bit hold_req      = 0;
  int cycles        = 0;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        chip.note_bus_item(cmd_e'(req_if.cmd), req_if.bus_address, req_if.write_data,
                           req_if.floating_bus);
      if (rsp_if.valid && rsp_if.ready)
        chip.check_rsp({rsp_if.read_data, rsp_if.handled, rsp_if.rom_bank, rsp_if.head_one,
                        rsp_if.internal_drive, rsp_if.select_35, rsp_if.iwm_reset_pulse});
    end
  end

  // result receiver: random stalls plus one long hold-off when hold_req is set
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // offer one bus item, idling at random first; returns right after the transfer
  task automatic put_item(cmd_e cmd, logic [15:0] addr, logic [7:0] wdata, logic [7:0] fbus);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.bus_address  <= addr;
    req_if.write_data   <= wdata;
    req_if.floating_bus <= fbus;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chip.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enhanced(bit value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    chip.enhanced = value;
    cfg_we_i <= 1'b0;
  endtask

  // address biased toward the decoded offsets, with some fully random ones
  function automatic logic [15:0] pick_addr();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(7))
        0: return {WIN_LO_PAGE, 8'h00} + 16'(OFF_IWM_RST);
        1: return {WIN_LO_PAGE, 8'h00} + 16'(OFF_DRV_ON) + 16'($urandom_range(31));
        2: return {WIN_LO_PAGE, 8'h00} + 16'(OFF_DRV_OFF) + 16'($urandom_range(31));
        3: return {WIN_LO_PAGE, 8'h00} + 16'($urandom_range(255));
        4, 5: return {WIN_HI_PAGE, 8'h00} + 16'($urandom_range(63));
        6: return {WIN_HI_PAGE, 8'h00} + 16'(OFF_SEL0 - OFF_RAM) + 16'($urandom_range(63));
        default: begin
          if ($urandom_range(9) == 0) return {WIN_LO_PAGE, 8'h00} + 16'(OFF_CUR_CLR);
          return {WIN_HI_PAGE, 8'h00} + 16'($urandom_range(255));
        end
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: return {WIN_LO_PAGE - 8'h01, 8'hFF};
        1: return {WIN_LO_PAGE + 8'h01, 8'h00};
        2: return {WIN_HI_PAGE - 8'h01, 8'hFF};
        default: return {WIN_HI_PAGE + 8'h01, 8'h00};
      endcase
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic put_random_item();
    int pick;
    cmd_e cmd;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CMD_READ;
    else if (pick < 92) cmd = CMD_WRITE;
    else if (pick < 96) cmd = CMD_TOGGLE;
    else cmd = CMD_NONE;
    put_item(cmd, pick_addr(), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // page sweep: a run of page RAM accesses, mostly cursor-advancing ones
  task automatic put_page_sweep(output int count);
    int len;
    logic [15:0] addr;
    len = $urandom_range(40, 80);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0) addr = {WIN_HI_PAGE, 8'h00} + 16'($urandom_range(31));
      else addr = {WIN_HI_PAGE, 8'h00} + 16'(OFF_RAM_ADV - OFF_RAM) + 16'($urandom_range(31));
      put_item(cmd_e'($urandom_range(1) ? CMD_WRITE : CMD_READ), addr,
               8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    count = len;
  endtask

  task automatic run_random(int n);
    int done;
    int got;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 12) begin
        put_page_sweep(got);
        done += got;
      end else begin
        put_random_item();
        done++;
      end
    end
  endtask

  // known corners: ram paging, cursor clear, every latch, window edges, unused command
  task automatic run_directed();
    logic [15:0] hi;
    logic [15:0] lo;
    hi = {WIN_HI_PAGE, 8'h00};
    lo = {WIN_LO_PAGE, 8'h00};
    if (chip.bank) put_item(CMD_TOGGLE, 16'h0000, 8'h00, 8'h00);
    put_item(CMD_TOGGLE, 16'hFFFF, 8'hFF, 8'hFF);
    put_item(CMD_WRITE, hi, 8'hFF, 8'h00);
    put_item(CMD_WRITE, hi + 16'h001F, 8'h00, 8'hFF);
    put_item(CMD_READ, hi, 8'h00, 8'h3C);
    put_item(CMD_READ, hi + 16'h001F, 8'h00, 8'hC3);
    put_item(CMD_WRITE, hi + 16'(OFF_RAM_ADV - OFF_RAM), 8'h5A, 8'h00);
    put_item(CMD_READ, hi + 16'(OFF_RAM_ADV_E - OFF_RAM), 8'h00, 8'h00);
    put_item(CMD_READ, lo + 16'(OFF_CUR_CLR), 8'h00, 8'h81);
    put_item(CMD_READ, hi, 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_IWM_RST), 8'hFF, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_DRV_ON_E), 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_DRV_OFF), 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_DRV_ON), 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_SEL1_E), 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_SEL0), 8'h00, 8'h00);
    put_item(CMD_WRITE, lo + 16'(OFF_SEL1), 8'h00, 8'h00);
    put_item(CMD_READ, lo + 16'(OFF_SEL1), 8'h00, 8'h00);
    put_item(CMD_READ, lo + 16'(OFF_SEL0_E), 8'h00, 8'h00);
    put_item(CMD_READ, lo + 16'(OFF_SEL1_E), 8'h00, 8'h00);
    put_item(CMD_READ, lo + 16'h00FF, 8'h00, 8'hA5);
    put_item(CMD_WRITE, hi + 16'h00FF, 8'h77, 8'h00);
    put_item(CMD_READ, lo - 16'h0001, 8'h00, 8'hFF);
    put_item(CMD_WRITE, hi + 16'h0100, 8'h11, 8'h00);
    put_item(CMD_NONE, hi, 8'hFF, 8'hFF);
    put_item(CMD_TOGGLE, hi, 8'h00, 8'h00);
    put_item(CMD_READ, hi, 8'h00, 8'h5C);
    put_item(CMD_TOGGLE, lo, 8'h00, 8'h00);
  endtask

  // reset, then config phases with directed and random traffic
  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_READ;
    req_if.bus_address  <= 16'h0000;
    req_if.write_data   <= 8'h00;
    req_if.floating_bus <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chip disabled: nothing handled, bank still toggles
    write_enhanced(1'b0);
    run_random(80);
    drain();

    write_enhanced(1'b1);
    run_directed();
    run_random(400);

    // full rate on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(300);

    // receiver holds off while items keep coming
    sink_idle_pct = 27;
    hold_req      = 1;
    run_random(200);
    src_idle_pct = 27;
    drain();

    write_enhanced(1'b0);
    run_random(100);
    drain();

    write_enhanced(1'b1);
    run_random(250);
    drain();
    repeat (10) @(posedge clk_i);

    if (chip.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
